[hdl/rs_erasure_decoder_prime_field_defines.svh]
// assertion macros used by the erasure decoder arithmetic unit
`ifndef RS_ERASURE_DECODER_PRIME_FIELD_DEFINES_SVH
`define RS_ERASURE_DECODER_PRIME_FIELD_DEFINES_SVH

// same-cycle implication under an active-low reset
`define RSED_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rsed check failed");

// next-cycle implication under an active-low reset
`define RSED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rsed check failed");

`endif

[hdl/rsed_pkg.sv]
// package with shared types, constants and field helpers of the erasure decoder
`default_nettype none
package rsed_pkg;

    localparam int MAX_LEN   = 32;
    localparam int LEN_W     = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int SYM_W     = 31;
    localparam int MASK_W    = 32;
    localparam int DVD_W     = 2 * SYM_W;
    localparam int STEP_W    = $clog2(DVD_W);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK     = 3'd3;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_op;

    typedef struct packed {
        logic [SYM_W-1:0]  modulus;
        logic [CNT_W-1:0]  code_len;
        logic [CNT_W-1:0]  data_len;
        logic [MASK_W-1:0] mask;
    } t_cfg;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [SYM_W-1:0] x;
        logic [SYM_W-1:0] y;
        logic [SYM_W-1:0] d;
    } t_arith_req;

    typedef struct packed {
        logic             done;
        logic [SYM_W-1:0] quo;
        logic [SYM_W-1:0] rem;
    } t_arith_rsp;

    // field subtraction, operands below q
    function automatic logic [SYM_W-1:0] f_sub(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b,
                                               input logic [SYM_W-1:0] q);
        logic [SYM_W:0] t;
        t = {1'b0, a} + {1'b0, q} - {1'b0, b};
        if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
        end
        return t[SYM_W-1:0];
    endfunction

    // field addition, operands below q
    function automatic logic [SYM_W-1:0] f_add(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b,
                                               input logic [SYM_W-1:0] q);
        logic [SYM_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, q}) begin
            t = t - {1'b0, q};
        end
        return t[SYM_W-1:0];
    endfunction

endpackage
`default_nettype wire

[hdl/rs_erasure_decoder_prime_field.sv]
// reed-solomon erasure decoder over a prime field: loads code_len symbols, then decodes
// decode: modular multiplies run on the shared arith unit; weights take k*(k-1) multiplies
// plus a divide and a multiply per euclid step, each erased data position k*(k+1)
// output: one data symbol per cycle unless stalled; next codeword loads as the last drains
// one codeword in flight at a time; no erasures among the data skips straight to output
// reset: synchronous active low, resets control and config; stores hold no reset value
`default_nettype none
module rs_erasure_decoder_prime_field import rsed_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [CFG_DAT_W-1:0] i_cfg_data,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire  [SYM_W-1:0]     i_code_symbol,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [SYM_W-1:0]     o_data_symbol,
    output logic [LEN_W-1:0]     o_position,
    output logic                 o_decode_ok,
    output logic                 o_last
);

    t_cfg       r_cfg;
    t_arith_req w_req;
    t_arith_rsp w_rsp;

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.modulus  <= {SYM_W{1'b1}};
            r_cfg.code_len <= CNT_W'(MAX_LEN);
            r_cfg.data_len <= CNT_W'(16);
            r_cfg.mask     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODULUS:  r_cfg.modulus  <= i_cfg_data[SYM_W-1:0];
                REG_CODE_LEN: r_cfg.code_len <= i_cfg_data[CNT_W-1:0];
                REG_DATA_LEN: r_cfg.data_len <= i_cfg_data[CNT_W-1:0];
                REG_MASK:     r_cfg.mask     <= i_cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and stores
    rsed_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_code_symbol (i_code_symbol),
        .o_req         (w_req),
        .i_rsp         (w_rsp),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data_symbol (o_data_symbol),
        .o_position    (o_position),
        .o_decode_ok   (o_decode_ok),
        .o_last        (o_last)
    );

    // shared modular multiply and divide
    rsed_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

endmodule
`default_nettype wire

[hdl/rsed_arith.sv]
// shared arithmetic unit: product or value reduced by restoring division
`default_nettype none
`include "rs_erasure_decoder_prime_field_defines.svh"
module rsed_arith import rsed_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_arith_req i_req,
    output t_arith_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [SYM_W-1:0]  r_rem;
    logic [SYM_W-1:0]  r_quo;
    logic [SYM_W-1:0]  r_div;

    logic [DVD_W-1:0]  w_prod;
    logic [SYM_W:0]    w_trial;
    logic [SYM_W:0]    w_diff;
    logic              w_ge;

    // one restoring step per cycle
    assign w_prod  = i_req.x * i_req.y;
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_req.d;
                if (i_req.op == OP_MUL) begin
                    r_dvd <= w_prod;
                end else begin
                    r_dvd <= DVD_W'(i_req.x);
                end
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[SYM_W-1:0] : w_trial[SYM_W-1:0];
                r_quo <= {r_quo[SYM_W-2:0], w_ge};
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    `RSED_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_req.start, !r_busy)
    `RSED_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)
    `RSED_ASSERT_IMP(a_rem_below, i_clk, i_rst_n, r_done, r_rem < r_div)

endmodule
`default_nettype wire

[hdl/rsed_ctrl.sv]
// sequencer with symbol, node and weight stores and the output register
`default_nettype none
module rsed_ctrl import rsed_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_cfg             i_cfg,
    input  wire              i_valid,
    output logic             o_stall,
    input  wire  [SYM_W-1:0] i_code_symbol,
    output t_arith_req       o_req,
    input  t_arith_rsp       i_rsp,
    output logic             o_valid,
    input  wire              i_stall,
    output logic [SYM_W-1:0] o_data_symbol,
    output logic [LEN_W-1:0] o_position,
    output logic             o_decode_ok,
    output logic             o_last
);

    typedef enum logic [17:0] {
        S_LOAD   = 18'h00001,
        S_DECIDE = 18'h00002,
        S_GATHER = 18'h00004,
        S_GRED   = 18'h00008,
        S_WINIT  = 18'h00010,
        S_WJ     = 18'h00020,
        S_WMUL   = 18'h00040,
        S_ETEST  = 18'h00080,
        S_EDIV   = 18'h00100,
        S_EMUL   = 18'h00200,
        S_ITEST  = 18'h00400,
        S_IRED   = 18'h00800,
        S_IM     = 18'h01000,
        S_IJ     = 18'h02000,
        S_IJMUL  = 18'h04000,
        S_ILI    = 18'h08000,
        S_IY     = 18'h10000,
        S_OUT    = 18'h20000
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_load_cnt;
    logic [SYM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_k;
    logic [MASK_W-1:0] r_mask;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_m;
    logic [CNT_W-1:0]  r_j;
    logic [LEN_W-1:0]  r_red;
    logic [LEN_W-1:0]  r_xm;
    logic [LEN_W-1:0]  r_xs;
    logic [SYM_W-1:0]  r_num;
    logic [SYM_W-1:0]  r_acc;
    logic [SYM_W-1:0]  r_r0;
    logic [SYM_W-1:0]  r_r1;
    logic [SYM_W-1:0]  r_t0;
    logic [SYM_W-1:0]  r_t1;
    logic              r_ok;
    t_arith_req        r_req;
    logic              r_ovalid;
    logic [SYM_W-1:0]  r_odata;
    logic [LEN_W-1:0]  r_opos;
    logic              r_ook;
    logic              r_olast;

    logic [SYM_W-1:0]  r_sym [MAX_LEN];
    logic [LEN_W-1:0]  r_pos [MAX_LEN];
    logic [LEN_W-1:0]  r_xr  [MAX_LEN];
    logic [SYM_W-1:0]  r_wt  [MAX_LEN];

    logic [SYM_W-1:0]  w_q;
    logic [CNT_W-1:0]  w_n;
    logic [CNT_W-1:0]  w_k;
    logic [MASK_W-1:0] w_low;
    logic              w_need;
    logic [LEN_W-1:0]  w_xaddr;
    logic [LEN_W-1:0]  w_xr;
    logic [LEN_W-1:0]  w_saddr;
    logic [SYM_W-1:0]  w_sym;
    logic [SYM_W-1:0]  w_wt;

    // clamped lengths and effective modulus
    always_comb begin
        w_q = (i_cfg.modulus < SYM_W'(2)) ? SYM_W'(2) : i_cfg.modulus;
        w_n = i_cfg.code_len;
        if (i_cfg.code_len == '0) begin
            w_n = CNT_W'(1);
        end else if (i_cfg.code_len > CNT_W'(MAX_LEN)) begin
            w_n = CNT_W'(MAX_LEN);
        end
        w_k = i_cfg.data_len;
        if (i_cfg.data_len == '0) begin
            w_k = CNT_W'(1);
        end else if (i_cfg.data_len > w_n) begin
            w_k = w_n;
        end
    end

    // erased data positions present
    always_comb begin
        for (int b = 0; b < MASK_W; b++) begin
            w_low[b] = (CNT_W'(b) < w_k);
        end
    end
    assign w_need = |(i_cfg.mask & w_low);

    // single read port on each store
    assign w_xaddr = (r_state == S_WINIT) ? r_m[LEN_W-1:0] : r_j[LEN_W-1:0];
    assign w_xr    = r_xr[w_xaddr];
    assign w_saddr = (r_state == S_OUT) ? r_i[LEN_W-1:0] : r_pos[r_m[LEN_W-1:0]];
    assign w_sym   = r_sym[w_saddr];
    assign w_wt    = r_wt[r_m[LEN_W-1:0]];

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_load_cnt  <= '0;
            r_ovalid    <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        r_sym[r_load_cnt[LEN_W-1:0]] <= i_code_symbol;
                        if (r_load_cnt + 1'b1 >= w_n) begin
                            r_load_cnt <= '0;
                            r_state    <= S_DECIDE;
                        end else begin
                            r_load_cnt <= r_load_cnt + 1'b1;
                        end
                    end
                end
                S_DECIDE: begin
                    r_q    <= w_q;
                    r_n    <= w_n;
                    r_k    <= w_k;
                    r_mask <= i_cfg.mask;
                    r_i    <= '0;
                    r_cnt  <= '0;
                    r_ok   <= 1'b1;
                    r_state <= w_need ? S_GATHER : S_OUT;
                end
                // pick the first k clean positions as nodes
                S_GATHER: begin
                    if (r_i == r_n) begin
                        r_i <= '0;
                        r_m <= '0;
                        if (r_cnt < r_k) begin
                            r_ok    <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_WINIT;
                        end
                    end else if (!r_mask[r_i[LEN_W-1:0]] && r_cnt < r_k) begin
                        r_red   <= r_i[LEN_W-1:0];
                        r_state <= S_GRED;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_GRED: begin
                    if (SYM_W'(r_red) >= r_q) begin
                        r_red <= r_red - r_q[LEN_W-1:0];
                    end else begin
                        r_pos[r_cnt[LEN_W-1:0]] <= r_i[LEN_W-1:0];
                        r_xr[r_cnt[LEN_W-1:0]]  <= r_red;
                        r_cnt   <= r_cnt + 1'b1;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_GATHER;
                    end
                end
                // barycentric denominator of node m
                S_WINIT: begin
                    if (r_m == r_k) begin
                        r_i     <= '0;
                        r_state <= S_ITEST;
                    end else begin
                        r_xm    <= w_xr;
                        r_num   <= SYM_W'(1);
                        r_j     <= '0;
                        r_state <= S_WJ;
                    end
                end
                S_WJ: begin
                    if (r_j == r_k) begin
                        r_r0    <= r_q;
                        r_r1    <= r_num;
                        r_t0    <= '0;
                        r_t1    <= SYM_W'(1);
                        r_state <= S_ETEST;
                    end else if (r_j == r_m) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.op    <= OP_MUL;
                        r_req.x     <= r_num;
                        r_req.y     <= f_sub(SYM_W'(r_xm), SYM_W'(w_xr), r_q);
                        r_req.d     <= r_q;
                        r_state     <= S_WMUL;
                    end
                end
                S_WMUL: begin
                    if (i_rsp.done) begin
                        r_num   <= i_rsp.rem;
                        r_j     <= r_j + 1'b1;
                        r_state <= S_WJ;
                    end
                end
                // extended euclid, coefficients kept as residues
                S_ETEST: begin
                    if (r_r1 == '0) begin
                        r_wt[r_m[LEN_W-1:0]] <= r_t0;
                        r_m     <= r_m + 1'b1;
                        r_state <= S_WINIT;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.op    <= OP_DIV;
                        r_req.x     <= r_r0;
                        r_req.y     <= r_r1;
                        r_req.d     <= r_r1;
                        r_state     <= S_EDIV;
                    end
                end
                S_EDIV: begin
                    if (i_rsp.done) begin
                        r_r0        <= r_r1;
                        r_r1        <= i_rsp.rem;
                        r_req.start <= 1'b1;
                        r_req.op    <= OP_MUL;
                        r_req.x     <= i_rsp.quo;
                        r_req.y     <= r_t1;
                        r_req.d     <= r_q;
                        r_state     <= S_EMUL;
                    end
                end
                S_EMUL: begin
                    if (i_rsp.done) begin
                        r_t0    <= r_t1;
                        r_t1    <= f_sub(r_t0, i_rsp.rem, r_q);
                        r_state <= S_ETEST;
                    end
                end
                // lagrange evaluation at each erased data position
                S_ITEST: begin
                    if (r_i == r_k) begin
                        r_i     <= '0;
                        r_state <= S_OUT;
                    end else if (!r_mask[r_i[LEN_W-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_red   <= r_i[LEN_W-1:0];
                        r_state <= S_IRED;
                    end
                end
                S_IRED: begin
                    if (SYM_W'(r_red) >= r_q) begin
                        r_red <= r_red - r_q[LEN_W-1:0];
                    end else begin
                        r_xs    <= r_red;
                        r_acc   <= '0;
                        r_m     <= '0;
                        r_state <= S_IM;
                    end
                end
                S_IM: begin
                    if (r_m == r_k) begin
                        r_sym[r_i[LEN_W-1:0]] <= r_acc;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ITEST;
                    end else begin
                        r_num   <= SYM_W'(1);
                        r_j     <= '0;
                        r_state <= S_IJ;
                    end
                end
                S_IJ: begin
                    if (r_j == r_k) begin
                        r_req.start <= 1'b1;
                        r_req.op    <= OP_MUL;
                        r_req.x     <= w_wt;
                        r_req.y     <= r_num;
                        r_req.d     <= r_q;
                        r_state     <= S_ILI;
                    end else if (r_j == r_m) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.op    <= OP_MUL;
                        r_req.x     <= r_num;
                        r_req.y     <= f_sub(SYM_W'(r_xs), SYM_W'(w_xr), r_q);
                        r_req.d     <= r_q;
                        r_state     <= S_IJMUL;
                    end
                end
                S_IJMUL: begin
                    if (i_rsp.done) begin
                        r_num   <= i_rsp.rem;
                        r_j     <= r_j + 1'b1;
                        r_state <= S_IJ;
                    end
                end
                S_ILI: begin
                    if (i_rsp.done) begin
                        r_req.start <= 1'b1;
                        r_req.op    <= OP_MUL;
                        r_req.x     <= w_sym;
                        r_req.y     <= i_rsp.rem;
                        r_req.d     <= r_q;
                        r_state     <= S_IY;
                    end
                end
                S_IY: begin
                    if (i_rsp.done) begin
                        r_acc   <= f_add(r_acc, i_rsp.rem, r_q);
                        r_m     <= r_m + 1'b1;
                        r_state <= S_IM;
                    end
                end
                // one data symbol per free slot of the output register
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= w_sym;
                        r_opos   <= r_i[LEN_W-1:0];
                        r_ook    <= r_ok;
                        r_olast  <= (r_i + 1'b1 == r_k);
                        if (r_i + 1'b1 == r_k) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_LOAD);
    assign o_req         = r_req;
    assign o_valid       = r_ovalid;
    assign o_data_symbol = r_odata;
    assign o_position    = r_opos;
    assign o_decode_ok   = r_ook;
    assign o_last        = r_olast;

endmodule
`default_nettype wire
